### src/grs_pkg.sv
// Shared types and constants for the grouped row statistics block.
package grs_pkg;

  // Field widths fixed by the item format
  localparam int MAP_W   = 6;
  localparam int SUM_W   = 28;
  localparam int SQ_W    = 43;
  localparam int CNT_W   = 13;
  localparam int VAL_W   = 16;
  localparam int VSQ_W   = 32;
  localparam int MEAN_W  = 16;
  localparam int VAR_W   = 32;

  // Index field spans
  localparam int ROW_SPAN = 1024;
  localparam int GRP_SPAN = 64;
  localparam int COL_SPAN = 4096;

  // Arithmetic unit widths
  localparam int MUL_W    = 28;
  localparam int PROD_W   = 56;
  localparam int QLO_W    = 28;
  localparam int QHI_W    = SQ_W - QLO_W;
  localparam int DVS_W    = 26;
  localparam int DIV_CW   = 6;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [CNT_W-1:0]  CNT_MAX       = 13'd8191;
  localparam logic [MEAN_W-1:0] MEAN_POS_MAX  = 16'h7FFF;
  localparam logic [MEAN_W-1:0] MEAN_NEG_MIN  = 16'h8000;
  localparam logic [VAR_W-1:0]  VAR_MAX       = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_ASSIGN = 2'd0,
    MODE_ENTRY  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MUL_SQ  = 2'd0,
    MUL_LO  = 2'd1,
    MUL_HI  = 2'd2,
    MUL_DEN = 2'd3
  } mul_op_t;

  typedef struct packed {
    mode_t              mode;
    logic [9:0]         row;
    logic [11:0]        column;
    logic [5:0]         group;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [27:0] group_sum;
    logic signed [15:0] group_mean;
    logic [31:0]        group_variance;
    logic [12:0]        group_size;
  } out_item_t;

  typedef struct packed {
    logic [SQ_W-1:0]  sq;
    logic [SUM_W-1:0] sum;
  } store_word_t;

  typedef struct packed {
    logic    latch;
    logic    map_wr;
    logic    map_rd;
    logic    cnt_rd;
    logic    cnt_inc;
    logic    clr_wr;
    logic    ent_rd;
    logic    ent_wr;
    logic    rd_rd;
    logic    stats_ld;
    logic    mul_en;
    mul_op_t mul_op;
    logic    num_ld;
    logic    div_start;
    logic    div_var;
    logic    mean_ld;
    logic    var_ld;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    mode_t in_mode;
    logic  in_ok;
    logic  clear_last;
    logic  div_done;
  } status_t;

endpackage

### src/grs_ctrl.sv
// Sequencer for the grouped row statistics block.
module grs_ctrl import grs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_CLEAR  = 16'h0002,
    ST_A_RD   = 16'h0004,
    ST_A_WR   = 16'h0008,
    ST_E_MAP  = 16'h0010,
    ST_E_RD   = 16'h0020,
    ST_E_WR   = 16'h0040,
    ST_R_RD   = 16'h0080,
    ST_R_LOAD = 16'h0100,
    ST_M_SQ   = 16'h0200,
    ST_M_LO   = 16'h0400,
    ST_M_HI   = 16'h0800,
    ST_M_DEN  = 16'h1000,
    ST_M_NUM  = 16'h2000,
    ST_D_MEAN = 16'h4000,
    ST_D_VAR  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_pend_r, out_pend_nxt;

  assign in_stall  = (state_r != ST_IDLE) || out_pend_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_pend_nxt  = out_pend_r;
    // pending result waits for the output register
    if (out_pend_r && (!out_valid_r || !out_stall)) begin
      cmd.out_ld    = 1'b1;
      out_valid_nxt = 1'b1;
      out_pend_nxt  = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !out_pend_r) begin
          cmd.latch = 1'b1;
          unique case (status.in_mode)
            MODE_ASSIGN: state_nxt = status.in_ok ? ST_A_RD : ST_IDLE;
            MODE_ENTRY:  state_nxt = status.in_ok ? ST_E_MAP : ST_IDLE;
            MODE_READ: begin
              if (status.in_ok) begin
                state_nxt = ST_R_RD;
              end else begin
                out_pend_nxt = 1'b1;
              end
            end
            MODE_CLEAR:  state_nxt = ST_CLEAR;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_A_RD: begin
        cmd.map_wr = 1'b1;
        cmd.cnt_rd = 1'b1;
        state_nxt  = ST_A_WR;
      end
      ST_A_WR: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_E_MAP: begin
        cmd.map_rd = 1'b1;
        state_nxt  = ST_E_RD;
      end
      ST_E_RD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = ST_E_WR;
      end
      ST_E_WR: begin
        cmd.ent_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_R_RD: begin
        cmd.rd_rd  = 1'b1;
        cmd.cnt_rd = 1'b1;
        state_nxt  = ST_R_LOAD;
      end
      ST_R_LOAD: begin
        cmd.stats_ld = 1'b1;
        state_nxt    = ST_M_SQ;
      end
      ST_M_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SQ;
        state_nxt  = ST_M_LO;
      end
      ST_M_LO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LO;
        state_nxt  = ST_M_HI;
      end
      ST_M_HI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_HI;
        state_nxt  = ST_M_DEN;
      end
      ST_M_DEN: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_DEN;
        state_nxt  = ST_M_NUM;
      end
      ST_M_NUM: begin
        cmd.num_ld    = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_D_MEAN;
      end
      ST_D_MEAN: begin
        if (status.div_done) begin
          cmd.mean_ld   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_var   = 1'b1;
          state_nxt     = ST_D_VAR;
        end
      end
      ST_D_VAR: begin
        if (status.div_done) begin
          cmd.var_ld   = 1'b1;
          out_pend_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      out_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_pend_r  <= out_pend_nxt;
    end
  end

endmodule

### src/grs_div.sv
// Restoring divider, one quotient bit per cycle.
module grs_div import grs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [PROD_W-1:0] dvd_r;
  logic [PROD_W-1:0] quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    diff;
  logic              ge;

  assign rem_sh   = {rem_r, dvd_r[PROD_W-1]};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[PROD_W-2:0], 1'b0};
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], ge};
    end
  end

endmodule

### src/grs_datapath.sv
// Tables, multiplier, divider and output register of the statistics block.
module grs_datapath import grs_pkg::*; #(
  parameter int ROWS    = 1024,
  parameter int COLUMNS = 4096,
  parameter int GROUPS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output status_t   status,
  output out_item_t out_data
);

  localparam int RUSED = (ROWS < ROW_SPAN) ? ROWS : ROW_SPAN;
  localparam int GUSED = (GROUPS < GRP_SPAN) ? GROUPS : GRP_SPAN;
  localparam int CUSED = (COLUMNS < COL_SPAN) ? COLUMNS : COL_SPAN;
  localparam int RW    = (RUSED > 1) ? $clog2(RUSED) : 1;
  localparam int GW    = (GUSED > 1) ? $clog2(GUSED) : 1;
  localparam int CW    = (CUSED > 1) ? $clog2(CUSED) : 1;
  localparam int AW    = RW + GW;
  localparam int STORE_DEPTH = 1 << AW;
  localparam int CNT_DEPTH   = 1 << GW;
  localparam int MAP_DEPTH   = 1 << CW;

  // latched item
  in_item_t                item_r;
  logic                    ok_r;
  logic [VSQ_W-1:0]        valsq_r;
  logic signed [VSQ_W-1:0] val_ext;
  logic                    row_ok, col_ok, grp_ok, in_ok;

  assign row_ok = (32'(in_data.row) < 32'(ROWS));
  assign col_ok = (32'(in_data.column) < 32'(COLUMNS));
  assign grp_ok = (32'(in_data.group) < 32'(GROUPS));

  // sign-extended value, squared at full width
  assign val_ext = VSQ_W'(in_data.value);

  always_comb begin
    unique case (in_data.mode)
      MODE_ASSIGN: in_ok = col_ok && grp_ok;
      MODE_ENTRY:  in_ok = row_ok && col_ok;
      MODE_READ:   in_ok = row_ok && grp_ok;
      MODE_CLEAR:  in_ok = 1'b1;
      default:     in_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r  <= in_data;
      ok_r    <= in_ok;
      valsq_r <= val_ext * val_ext;
    end
  end

  // column to group map
  logic [MAP_W-1:0] map_mem [MAP_DEPTH];
  logic [MAP_W-1:0] map_q_r;

  always_ff @(posedge clk) begin
    if (cmd.map_wr) begin
      map_mem[item_r.column[CW-1:0]] <= item_r.group;
    end
    if (cmd.map_rd) begin
      map_q_r <= map_mem[item_r.column[CW-1:0]];
    end
  end

  // clear sweep pointer
  logic [AW-1:0] clr_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_ptr_r <= clr_ptr_r + 1'b1;
    end
  end

  // group sizes
  logic [CNT_W-1:0] cnt_mem [CNT_DEPTH];
  logic [CNT_W-1:0] cnt_q_r;
  logic [GW-1:0]    cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;

  assign cnt_waddr = cmd.clr_wr ? clr_ptr_r[GW-1:0] : item_r.group[GW-1:0];
  assign cnt_wdata = cmd.clr_wr ? '0 :
                     ((cnt_q_r == CNT_MAX) ? cnt_q_r : cnt_q_r + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.cnt_inc) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd.cnt_rd) begin
      cnt_q_r <= cnt_mem[item_r.group[GW-1:0]];
    end
  end

  // per row and group sums
  store_word_t store_mem [STORE_DEPTH];
  store_word_t store_q_r;
  store_word_t upd;
  logic [AW-1:0] ent_addr, rd_addr, raddr, ent_addr_r, waddr;
  logic          we;

  assign ent_addr = {item_r.row[RW-1:0], map_q_r[GW-1:0]};
  assign rd_addr  = {item_r.row[RW-1:0], item_r.group[GW-1:0]};
  assign raddr    = cmd.ent_rd ? ent_addr : rd_addr;
  assign waddr    = cmd.clr_wr ? clr_ptr_r : ent_addr_r;
  assign we       = cmd.clr_wr || cmd.ent_wr;

  assign upd.sum = store_q_r.sum + {{(SUM_W-VAL_W){item_r.value[VAL_W-1]}}, item_r.value};
  assign upd.sq  = store_q_r.sq + {{(SQ_W-VSQ_W){1'b0}}, valsq_r};

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= cmd.clr_wr ? '0 : upd;
    end
    if (cmd.ent_rd || cmd.rd_rd) begin
      store_q_r <= store_mem[raddr];
    end
    if (cmd.ent_rd) begin
      ent_addr_r <= ent_addr;
    end
  end

  // readout arithmetic
  logic [SUM_W-1:0]  s_r;
  logic [SQ_W-1:0]   q_r;
  logic [CNT_W-1:0]  n_r;
  logic [MUL_W-1:0]  smag, mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sq_r, acc_r;
  logic [QLO_W-1:0]  hi_r;
  logic [DVS_W-1:0]  den_r;
  logic [PROD_W:0]   num_r;
  logic              num_pos, n_small;
  logic [CNT_W-1:0]  n_safe;

  assign smag    = s_r[SUM_W-1] ? (~s_r + 1'b1) : s_r;
  assign n_small = (n_r < CNT_W'(2));
  assign n_safe  = n_small ? CNT_W'(1) : n_r;
  assign num_pos = !num_r[PROD_W] && (|num_r[PROD_W-1:0]);

  always_comb begin
    unique case (cmd.mul_op)
      MUL_SQ: begin
        mul_a = smag;
        mul_b = smag;
      end
      MUL_LO: begin
        mul_a = MUL_W'(n_r);
        mul_b = q_r[QLO_W-1:0];
      end
      MUL_HI: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(q_r[SQ_W-1:QLO_W]);
      end
      MUL_DEN: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(n_r - 1'b1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {{(PROD_W-MUL_W){1'b0}}, mul_a} * {{(PROD_W-MUL_W){1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    if (cmd.stats_ld) begin
      s_r <= store_q_r.sum;
      q_r <= store_q_r.sq;
      n_r <= cnt_q_r;
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_op)
        MUL_SQ: sq_r <= prod;
        MUL_LO: acc_r <= prod;
        MUL_HI: hi_r <= prod[QLO_W-1:0];
        MUL_DEN: begin
          den_r <= prod[DVS_W-1:0];
          acc_r <= acc_r + {hi_r, {QLO_W{1'b0}}};
        end
        default: ;
      endcase
    end
    if (cmd.num_ld) begin
      num_r <= {1'b0, acc_r} - {1'b0, sq_r};
    end
  end

  // shared divider: mean first, then variance
  logic [PROD_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;

  assign div_dvd = cmd.div_var ? num_r[PROD_W-1:0] : PROD_W'(smag);
  assign div_dvs = cmd.div_var ? den_r : DVS_W'(n_safe);

  grs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  var_r;
  logic [MEAN_W-1:0] mean_val;

  always_comb begin
    if (s_r[SUM_W-1]) begin
      mean_val = (div_quo > PROD_W'(32768)) ? MEAN_NEG_MIN : (~div_quo[MEAN_W-1:0] + 1'b1);
    end else begin
      mean_val = (div_quo > PROD_W'(32767)) ? MEAN_POS_MAX : div_quo[MEAN_W-1:0];
    end
  end

  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      mean_r <= mean_val;
    end
    if (cmd.var_ld) begin
      if (n_small || !num_pos) begin
        var_r <= '0;
      end else begin
        var_r <= (|div_quo[PROD_W-1:VAR_W]) ? VAR_MAX : div_quo[VAR_W-1:0];
      end
    end
    if (cmd.out_ld) begin
      if (ok_r) begin
        out_r.group_sum      <= s_r;
        out_r.group_mean     <= mean_r;
        out_r.group_variance <= var_r;
        out_r.group_size     <= n_r;
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_data = out_r;

  assign status.in_mode    = in_data.mode;
  assign status.in_ok      = in_ok;
  assign status.clear_last = &clr_ptr_r;
  assign status.div_done   = div_done;

endmodule

### src/grouped_row_statistics_core.sv
// Top level of the grouped row statistics block: controller plus datapath.
//
// Keeps, for every row and column group, the sum and the sum of squares of
// the Q8.8 entries seen, and the number of columns in each group. Requests
// are taken one at a time. A column assignment writes the map and reads the
// group size, then writes it back incremented; an entry does a map read, a
// table read and a table write (a read-modify-write of one table word). A
// readout makes four passes through one 28x28 multiplier and then runs the
// shared one-bit-per-cycle divider twice (mean, then variance) before it
// shows on out_valid. A clear sweeps the sum table one word a cycle, all
// 2^(log2 rows + log2 groups) words (65536 at the default sizes), and zeroes
// the group sizes; the same sweep runs straight after reset, and no request
// is taken until it ends. A finished readout sits in the output register,
// and the next request is taken while it waits. Out of range indices are
// ignored, except a readout, which returns all zeros.
module grouped_row_statistics_core import grs_pkg::*; #(
  parameter int ROWS    = 1024,
  parameter int COLUMNS = 4096,
  parameter int GROUPS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer: owns handshakes and the order of table and arithmetic steps
  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // tables, arithmetic and the output register
  grs_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .GROUPS  (GROUPS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

### tb/tb_grouped_row_statistics_core.sv
// Testbench for grouped_row_statistics_core: directed and random requests, predicted readouts.
module tb_grouped_row_statistics_core;
  import grs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 550;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_CYCLES     = 3000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  grouped_row_statistics_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow of the block's tables
  logic [5:0]  col_group [COL_SPAN];
  int          grp_size  [GRP_SPAN];
  logic [27:0] cell_sum  [ROW_SPAN*GRP_SPAN];
  logic [42:0] cell_sq   [ROW_SPAN*GRP_SPAN];

  // Map as planned while the request list is built
  int          plan_group [COL_SPAN];

  in_item_t  pending[$];
  out_item_t stats_due[$];
  int        mapped_cols[$];

  int  issued = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  send_idle_pct = 19;
  int  recv_idle_pct = 87;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  bit  took_in = 1'b0;

  function automatic void clear_tables();
    for (int g = 0; g < GRP_SPAN; g++) grp_size[g] = 0;
    for (int i = 0; i < ROW_SPAN*GRP_SPAN; i++) begin
      cell_sum[i] = '0;
      cell_sq[i]  = '0;
    end
  endfunction

  // Apply one accepted request to the shadow; a readout queues its statistics
  function automatic void predict_request(in_item_t r);
    int        idx;
    longint    v, sq, n, s, q, mean, num, var_q;
    out_item_t st;
    case (r.mode)
      MODE_ASSIGN: begin
        col_group[r.column] = r.group;
        if (grp_size[r.group] < 8191) grp_size[r.group]++;
      end
      MODE_ENTRY: begin
        idx = r.row * GRP_SPAN + col_group[r.column];
        v = r.value;
        sq = v * v;
        cell_sum[idx] = cell_sum[idx] + v[27:0];
        cell_sq[idx]  = cell_sq[idx] + sq[42:0];
      end
      MODE_CLEAR: clear_tables();
      default: begin
        idx = r.row * GRP_SPAN + r.group;
        n = grp_size[r.group];
        s = $signed(cell_sum[idx]);
        q = {21'b0, cell_sq[idx]};
        mean = s / (n > 1 ? n : 1);
        if (mean > 32767) mean = 32767;
        if (mean < -32768) mean = -32768;
        var_q = 0;
        if (n >= 2) begin
          num = n * q - s * s;
          if (num > 0) begin
            var_q = num / (n * (n - 1));
            if (var_q > 64'hFFFF_FFFF) var_q = 64'hFFFF_FFFF;
          end
        end
        st.group_sum      = s[27:0];
        st.group_mean     = mean[15:0];
        st.group_variance = var_q[31:0];
        st.group_size     = n[12:0];
        stats_due.push_back(st);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic void add_request(mode_t m, int row, int col, int grp, int val);
    in_item_t r;
    r.mode   = m;
    r.row    = row[9:0];
    r.column = col[11:0];
    r.group  = grp[5:0];
    r.value  = val[15:0];
    pending.push_back(r);
    if (m == MODE_ASSIGN) begin
      mapped_cols.push_back(col);
      plan_group[col[11:0]] = grp[5:0];
    end
  endfunction

  function automatic int pick_row();
    return ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(1023);
  endfunction

  // Sender: new request offered at the falling edge once the last one was taken
  always @(posedge clk) took_in <= rst_n && in_valid && !in_stall;

  // Shadow tables start cleared with the block, then follow accepted requests
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COL_SPAN; c++) col_group[c] = '0;
      clear_tables();
    end else if (in_valid && !in_stall) begin
      predict_request(in_data);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_in) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
        issued   <= issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Idling phases follow the number of requests issued
  always @(negedge clk) begin
    if (issued < 190) begin
      send_idle_pct <= 19;
      recv_idle_pct <= 87;
    end else if (issued < 380) begin
      send_idle_pct <= 87;
      recv_idle_pct <= 19;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held_once && issued >= 120) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Readout checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (stats_due.size() == 0) begin
        report_mismatch("readout with none pending", out_data.group_sum, 0);
      end else begin
        want = stats_due.pop_front();
        if (out_data.group_sum != want.group_sum)
          report_mismatch("group_sum", out_data.group_sum, want.group_sum);
        if (out_data.group_mean != want.group_mean)
          report_mismatch("group_mean", out_data.group_mean, want.group_mean);
        if (out_data.group_variance != want.group_variance)
          report_mismatch("group_variance", out_data.group_variance, want.group_variance);
        if (out_data.group_size != want.group_size)
          report_mismatch("group_size", out_data.group_size, want.group_size);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("grouped_row_statistics_core test failed");
      $finish;
    end
  end

  initial begin
    int r, col, val;
    rst_n = 1'b0;

    // Directed: empty cell, top extremes, mean saturation both ways,
    // negative variance numerator, variance near its maximum, reassigned column, clear
    add_request(MODE_READ,   1023, 0,    63, 0);
    add_request(MODE_ASSIGN, 0,    0,    1,  0);
    add_request(MODE_ASSIGN, 0,    4095, 1,  0);
    add_request(MODE_ASSIGN, 0,    5,    63, 0);
    add_request(MODE_ENTRY,  1023, 0,    0,  32767);
    add_request(MODE_ENTRY,  1023, 4095, 0,  -32768);
    add_request(MODE_READ,   1023, 0,    1,  0);
    repeat (3) add_request(MODE_ENTRY, 0, 5, 0, 32767);
    add_request(MODE_READ,   0,    0,    63, 0);
    repeat (2) add_request(MODE_ENTRY, 1, 5, 0, -32768);
    add_request(MODE_READ,   1,    0,    63, 0);
    repeat (3) add_request(MODE_ENTRY, 2, 0, 0, 256);
    add_request(MODE_READ,   2,    0,    1,  0);
    repeat (2) begin
      add_request(MODE_ENTRY, 3, 0, 0, 32767);
      add_request(MODE_ENTRY, 3, 0, 0, -32768);
    end
    add_request(MODE_READ,   3,    0,    1,  0);
    add_request(MODE_ASSIGN, 0,    4095, 2,  0);
    add_request(MODE_ENTRY,  4,    4095, 0,  100);
    add_request(MODE_READ,   4,    0,    2,  0);
    add_request(MODE_CLEAR,  0,    0,    0,  0);
    add_request(MODE_READ,   1023, 0,    1,  0);

    // Random: mostly entries into a few busy rows, with assigns, readouts
    // and one clear half way; entries only hit mapped columns
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      r = $urandom_range(99);
      if (i == RANDOM_REQUESTS / 2) begin
        add_request(MODE_CLEAR, $urandom_range(1023), $urandom_range(4095),
                    $urandom_range(63), $urandom_range(65535));
      end else if (r < 12) begin
        add_request(MODE_ASSIGN, $urandom_range(1023), $urandom_range(4095),
                    ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(63),
                    $urandom_range(65535));
      end else if (r < 80) begin
        col = mapped_cols[$urandom_range(mapped_cols.size() - 1)];
        case ($urandom_range(9))
          0:       val = 32767;
          1:       val = -32768;
          default: val = $urandom_range(65535);
        endcase
        add_request(MODE_ENTRY, pick_row(), col, $urandom_range(63), val);
      end else if (r < 95) begin
        col = mapped_cols[$urandom_range(mapped_cols.size() - 1)];
        add_request(MODE_READ, pick_row(), $urandom_range(4095), plan_group[col],
                    $urandom_range(65535));
      end else begin
        add_request(MODE_READ, $urandom_range(1023), $urandom_range(4095),
                    $urandom_range(63), $urandom_range(65535));
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || in_valid) @(posedge clk);
    while (stats_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("grouped_row_statistics_core test passed");
    end else begin
      $display("grouped_row_statistics_core test failed");
    end
    $finish;
  end

endmodule
